### rtl/core/mandatory_ie_checker_unit_assert.svh
// Assertion macros used by mic_port_checker.
`ifndef MANDATORY_IE_CHECKER_UNIT_ASSERT_SVH
`define MANDATORY_IE_CHECKER_UNIT_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define MIC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mic assertion failed");

// Next-cycle implication, held off during reset.
`define MIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("mic assertion failed");

`endif

### rtl/core/mic_pkg.sv
// ----------------------------------------------------------------------------
// mic_pkg
// Types and constants of the mandatory information element checker.
// ----------------------------------------------------------------------------
package mic_pkg;

	localparam int unsigned ELEM_HDR_BYTES = 2;
	localparam int unsigned NUM_RULES      = 3;

	// Element rules: bit 0 SSID, bit 1 supported rates, bit 2 DS parameter set
	localparam logic [NUM_RULES-1:0][7:0] RULE_ID  = {8'd3, 8'd1, 8'd0};
	localparam logic [NUM_RULES-1:0][7:0] RULE_MIN = {8'd1, 8'd1, 8'd0};
	localparam logic [NUM_RULES-1:0][7:0] RULE_MAX = {8'd255, 8'd255, 8'd32};

	localparam logic [15:0] POS_LIMIT   = 16'hFFFF;
	localparam logic [16:0] START_LIMIT = 17'h1FFFF;

	typedef struct packed {
		logic frame_accepted;
		logic ssid_present;
		logic rates_present;
		logic ds_present;
	} result_t;

endpackage

### rtl/core/mic_in_if.sv
// ----------------------------------------------------------------------------
// mic_in_if
// Byte stream channel carrying frame bytes and the end-of-frame marker.
// ----------------------------------------------------------------------------
interface mic_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_end;

	modport source (output valid, output frame_byte, output frame_end, input ready);
	modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

### rtl/core/mic_out_if.sv
// ----------------------------------------------------------------------------
// mic_out_if
// Result channel carrying the per-frame verdict and element flags.
// ----------------------------------------------------------------------------
interface mic_out_if;
	logic valid;
	logic ready;
	logic frame_accepted;
	logic ssid_present;
	logic rates_present;
	logic ds_present;

	modport source (output valid, output frame_accepted, output ssid_present,
		output rates_present, output ds_present, input ready);
	modport sink   (input valid, input frame_accepted, input ssid_present,
		input rates_present, input ds_present, output ready);
endinterface

### rtl/core/mandatory_ie_checker_unit.sv
// ----------------------------------------------------------------------------
// mandatory_ie_checker_unit
// Checks a scanned 802.11 management frame for SSID, rates and DS elements.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one frame byte per beat; frame_end marks the last byte.
//   out_ch carries one result beat per frame: the three element flags and
//   frame_accepted, which is high when all three were found.
//   Result path: the beat with frame_end is taken into the input register,
//   then loaded into the result register once that register is free or
//   its beat is being taken.
//   Throughput: one byte per cycle while no closing byte is held (see Stalls).
//   The parse state is updated once per byte, so bytes may follow back to
//   back, also across frame boundaries.
//   Stalls: a pending result sits in the output register while bytes keep
//   flowing; in_ch.ready only drops when a second closing byte reaches the
//   input register before the first result has been taken.
//   Reset: arst_n clears the valid bits of both registers and the parse state;
//   the payloads are not reset. The first byte after reset starts a fresh frame.
// ----------------------------------------------------------------------------
module mandatory_ie_checker_unit import mic_pkg::*; #(
	parameter int unsigned LENGTH_FIELD_OFFSET = 4,
	parameter int unsigned HEADER_LENGTH       = 12,
	parameter int unsigned BODY_OFFSET         = 36
) (
	input  logic      clk,
	input  logic      arst_n,
	mic_in_if.sink    in_ch,
	mic_out_if.source out_ch
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// result register
	logic       out_valid_q;
	result_t    out_res_q;

	result_t    walk_res;
	logic       advance;

	// Hold the byte in s1 only when it closes a frame and the result
	// register is still occupied by an untaken beat.
	assign advance     = valid_s1 && !(end_s1 && out_valid_q && !out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	mic_ie_walker #(
		.LENGTH_FIELD_OFFSET (LENGTH_FIELD_OFFSET),
		.HEADER_LENGTH       (HEADER_LENGTH),
		.BODY_OFFSET         (BODY_OFFSET)
	) u_walker (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.frame_byte (byte_s1),
		.frame_end  (end_s1),
		.res        (walk_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.frame_byte;
			end_s1  <= in_ch.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && end_s1) begin
			out_res_q <= walk_res;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.frame_accepted = out_res_q.frame_accepted;
	assign out_ch.ssid_present   = out_res_q.ssid_present;
	assign out_ch.rates_present  = out_res_q.rates_present;
	assign out_ch.ds_present     = out_res_q.ds_present;

endmodule

### rtl/core/mic_ie_walker.sv
// ----------------------------------------------------------------------------
// mic_ie_walker
// Per-frame parse state: length word capture, element walk, found flags.
// ----------------------------------------------------------------------------
module mic_ie_walker import mic_pkg::*; #(
	parameter int unsigned LENGTH_FIELD_OFFSET = 4,
	parameter int unsigned HEADER_LENGTH       = 12,
	parameter int unsigned BODY_OFFSET         = 36
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] frame_byte,
	input  logic       frame_end,
	output result_t    res
);

	localparam logic [16:0] LFO_START  = 17'(LENGTH_FIELD_OFFSET);
	localparam logic [16:0] LFO_END    = 17'(LENGTH_FIELD_OFFSET) + 17'd4;
	localparam logic [15:0] LFO_LOW    = 16'(LENGTH_FIELD_OFFSET);
	localparam logic [15:0] HDR_LEN    = 16'(HEADER_LENGTH);
	localparam logic [16:0] BODY_START = 17'(BODY_OFFSET);

	logic [15:0] pos_q;
	logic [15:0] len_q;       // only the low half of the length word matters
	logic [15:0] decl_q;
	logic [16:0] nes_q;
	logic [7:0]  id_q;
	logic        counts_q;
	logic [2:0]  flags_q;

	logic        active;
	logic        in_len;
	logic [1:0]  lane;
	logic [15:0] len_nxt;
	logic [15:0] decl_cur;
	logic        at_start;
	logic        at_len;
	logic [17:0] nes_sum;
	logic [16:0] nes_nxt;
	logic [2:0]  hit;
	logic [2:0]  flags_nxt;

	always_comb begin
		active = (pos_q != POS_LIMIT);
		in_len = ({1'b0, pos_q} >= LFO_START) && ({1'b0, pos_q} < LFO_END);
		lane   = 2'(pos_q - LFO_LOW);
		len_nxt = len_q;
		case (lane)
			2'd0:    len_nxt[7:0]  = frame_byte;
			2'd1:    len_nxt[15:8] = frame_byte;
			default: len_nxt       = len_q;
		endcase
		decl_cur = (in_len) ? (len_nxt + HDR_LEN) : decl_q;

		at_start = ({1'b0, pos_q} == nes_q);
		at_len   = (nes_q != START_LIMIT) && ({1'b0, pos_q} == nes_q + 17'd1);

		nes_sum = 18'(nes_q) + 18'(frame_byte) + 18'(ELEM_HDR_BYTES);
		nes_nxt = (nes_sum > 18'(START_LIMIT)) ? START_LIMIT : nes_sum[16:0];

		for (int r = 0; r < NUM_RULES; r++) begin
			hit[r] = (id_q == RULE_ID[r]) && (frame_byte >= RULE_MIN[r]) &&
				(frame_byte <= RULE_MAX[r]);
		end

		flags_nxt = flags_q;
		if (active && !at_start && at_len && counts_q)
			flags_nxt = flags_q | hit;

		res.ssid_present   = flags_nxt[0];
		res.rates_present  = flags_nxt[1];
		res.ds_present     = flags_nxt[2];
		res.frame_accepted = &flags_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			len_q    <= '0;
			decl_q   <= '0;
			nes_q    <= BODY_START;
			id_q     <= '0;
			counts_q <= 1'b0;
			flags_q  <= '0;
		end else if (step) begin
			if (frame_end) begin
				// close the frame: back to the reset state
				pos_q    <= '0;
				len_q    <= '0;
				decl_q   <= '0;
				nes_q    <= BODY_START;
				id_q     <= '0;
				counts_q <= 1'b0;
				flags_q  <= '0;
			end else if (active) begin
				pos_q   <= pos_q + 16'd1;
				flags_q <= flags_nxt;
				if (in_len) begin
					len_q  <= len_nxt;
					decl_q <= decl_cur;
				end
				if (at_start) begin
					id_q     <= frame_byte;
					counts_q <= (pos_q < decl_cur);
				end else if (at_len) begin
					nes_q    <= nes_nxt;
					counts_q <= 1'b0;
				end
			end
		end
	end

endmodule

### rtl/core/mic_port_checker.sv
// ----------------------------------------------------------------------------
// mic_port_checker
// Port-level checks of the checker unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "mandatory_ie_checker_unit_assert.svh"

module mic_port_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_frame_end,
	input logic out_valid,
	input logic out_ready,
	input logic out_frame_accepted,
	input logic out_ssid_present,
	input logic out_rates_present,
	input logic out_ds_present
);

	`MIC_ASSERT_IMPL(a_accept_is_and, clk, arst_n, out_valid,
		out_frame_accepted == (out_ssid_present && out_rates_present && out_ds_present))

	`MIC_ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)

	// a fresh result must be preceded by a taken closing beat
	`MIC_ASSERT_IMPL(a_result_follows_end, clk, arst_n, $rose(out_valid),
		$past(in_valid && in_ready && in_frame_end, 2))

	`MIC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_frame_accepted) && $stable(out_ssid_present) &&
		$stable(out_rates_present) && $stable(out_ds_present))

endmodule

bind mandatory_ie_checker_unit mic_port_checker u_port_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (in_ch.valid),
	.in_ready           (in_ch.ready),
	.in_frame_end       (in_ch.frame_end),
	.out_valid          (out_ch.valid),
	.out_ready          (out_ch.ready),
	.out_frame_accepted (out_ch.frame_accepted),
	.out_ssid_present   (out_ch.ssid_present),
	.out_rates_present  (out_ch.rates_present),
	.out_ds_present     (out_ch.ds_present)
);
